[hw/rtl/rau_pkg.sv]
// Shared types and constants for the rational arithmetic unit.
// No dependencies; used by rau_ctrl, rau_datapath and rational_arith_unit_core.
package rau_pkg;

  localparam int OPERAND_BITS = 32;
  localparam int PROD_W       = 2 * OPERAND_BITS;
  localparam int VAL_W        = 64;
  localparam int CNT_W        = $clog2(VAL_W + 1);
  localparam int SHIFT_W      = $clog2(VAL_W);

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZDIV = 2'd1,
    STAT_OVF  = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_SUM,
    OP_GCD_INIT,
    OP_GCD_STEP,
    OP_DIVN_INIT,
    OP_DIV_STEP,
    OP_DIVD_INIT,
    OP_FIN
  } dp_op_e;

  typedef enum logic [1:0] {
    RES_NORM,
    RES_ZERO,
    RES_ERR
  } res_kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_CHECK,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FIN
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e    op;
    res_kind_e kind;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic addsub;
    logic zero;
    logic gcd_done;
    logic div_done;
  } dp_stat_t;

endpackage

[hw/rtl/rau_datapath.sv]
// Datapath of the rational arithmetic unit: operands, shared multiplier,
// adder, binary GCD, shared restoring divider and result registers. Uses rau_pkg.
module rau_datapath (
  input  logic                                clk_i,
  input  rau_pkg::dp_cmd_t                    cmd_i,
  output rau_pkg::dp_stat_t                   stat_o,
  input  logic [1:0]                          func_i,
  input  logic [rau_pkg::OPERAND_BITS-1:0]    a_num_i,
  input  logic [rau_pkg::OPERAND_BITS-1:0]    a_den_i,
  input  logic [rau_pkg::OPERAND_BITS-1:0]    b_num_i,
  input  logic [rau_pkg::OPERAND_BITS-1:0]    b_den_i,
  output logic signed [63:0]                  res_num_o,
  output logic [62:0]                         res_den_o,
  output logic [1:0]                          status_o
);

  localparam int OB = rau_pkg::OPERAND_BITS;
  localparam int VW = rau_pkg::VAL_W;
  localparam int PW = rau_pkg::PROD_W;

  // Operand magnitudes and signs
  logic [OB-1:0] an_q, ad_q, bn_q, bd_q;
  logic          an_s_q, ad_s_q, bn_s_q, bd_s_q;
  rau_pkg::func_e func_q;

  // Intermediate values
  logic [VW-1:0] n0_q, n1_q, num_q, den_q;
  logic          n0_s_q, n1_s_q, num_s_q, den_s_q;
  logic [VW-1:0] u_q, v_q, g_q, rem_q, quo_q, nq_q;
  logic [rau_pkg::SHIFT_W-1:0] k_q;
  logic [rau_pkg::CNT_W-1:0]   cnt_q;

  logic signed [63:0] res_num_q;
  logic [62:0]        res_den_q;
  rau_pkg::stat_e     status_q;

  // Convert a raw operand to sign and magnitude
  function automatic logic [OB:0] to_smag(input logic [OB-1:0] v);
    logic [OB-1:0] m;
    m = v[OB-1] ? (~v + OB'(1)) : v;
    return {v[OB-1], m};
  endfunction

  logic [OB:0] an_c, ad_c, bn_c, bd_c;
  assign an_c = to_smag(a_num_i);
  assign ad_c = to_smag(a_den_i);
  assign bn_c = to_smag(b_num_i);
  assign bd_c = to_smag(b_den_i);

  // Shared multiplier operand select
  logic [OB-1:0] mul_a, mul_b;
  logic          mul_s;
  logic [PW-1:0] prod;
  logic          is_div, is_mul, is_sub;
  assign is_div = (func_q == rau_pkg::FUNC_DIV);
  assign is_mul = (func_q == rau_pkg::FUNC_MUL);
  assign is_sub = (func_q == rau_pkg::FUNC_SUB);

  always_comb begin
    unique case (cmd_i.op)
      rau_pkg::OP_MUL0: begin
        mul_a = an_q;
        mul_b = is_mul ? bn_q : bd_q;
        mul_s = an_s_q ^ (is_mul ? bn_s_q : bd_s_q);
      end
      rau_pkg::OP_MUL1: begin
        mul_a = bn_q;
        mul_b = ad_q;
        mul_s = bn_s_q ^ ad_s_q ^ is_sub;
      end
      default: begin
        mul_a = ad_q;
        mul_b = is_div ? bn_q : bd_q;
        mul_s = ad_s_q ^ (is_div ? bn_s_q : bd_s_q);
      end
    endcase
  end
  assign prod = PW'(mul_a) * PW'(mul_b);

  // Signed-magnitude sum
  logic [VW-1:0] sum_mag;
  logic          sum_s;
  always_comb begin
    if (n0_s_q == n1_s_q) begin
      sum_mag = n0_q + n1_q;
      sum_s   = n0_s_q;
    end else if (n0_q >= n1_q) begin
      sum_mag = n0_q - n1_q;
      sum_s   = n0_s_q;
    end else begin
      sum_mag = n1_q - n0_q;
      sum_s   = n1_s_q;
    end
  end

  // Restoring divider trial subtract
  logic [VW:0] trial, trial_sub;
  assign trial     = {rem_q, quo_q[VW-1]};
  assign trial_sub = trial - {1'b0, g_q};

  // Final numerator formatting
  logic [VW-1:0] neg_nq;
  assign neg_nq = ~nq_q + VW'(1);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      rau_pkg::OP_LOAD: begin
        func_q <= rau_pkg::func_e'(func_i);
        {an_s_q, an_q} <= an_c;
        {ad_s_q, ad_q} <= ad_c;
        {bn_s_q, bn_q} <= bn_c;
        {bd_s_q, bd_q} <= bd_c;
        n1_q   <= '0;
        n1_s_q <= 1'b0;
      end
      rau_pkg::OP_MUL0: begin
        n0_q   <= VW'(prod);
        n0_s_q <= mul_s;
      end
      rau_pkg::OP_MUL1: begin
        n1_q   <= VW'(prod);
        n1_s_q <= mul_s;
      end
      rau_pkg::OP_MUL2: begin
        den_q   <= VW'(prod);
        den_s_q <= mul_s;
      end
      rau_pkg::OP_SUM: begin
        num_q   <= sum_mag;
        num_s_q <= sum_s;
      end
      rau_pkg::OP_GCD_INIT: begin
        u_q <= num_q;
        v_q <= den_q;
        k_q <= '0;
      end
      // One binary GCD step
      rau_pkg::OP_GCD_STEP: begin
        if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= (u_q - v_q) >> 1;
        end else begin
          v_q <= (v_q - u_q) >> 1;
        end
      end
      rau_pkg::OP_DIVN_INIT: begin
        g_q   <= (u_q | v_q) << k_q;
        rem_q <= '0;
        quo_q <= num_q;
        cnt_q <= '0;
      end
      rau_pkg::OP_DIVD_INIT: begin
        nq_q  <= quo_q;
        rem_q <= '0;
        quo_q <= den_q;
        cnt_q <= '0;
      end
      rau_pkg::OP_DIV_STEP: begin
        if (!trial_sub[VW]) begin
          rem_q <= trial_sub[VW-1:0];
          quo_q <= {quo_q[VW-2:0], 1'b1};
        end else begin
          rem_q <= trial[VW-1:0];
          quo_q <= {quo_q[VW-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
      end
      // Form the result transaction
      rau_pkg::OP_FIN: begin
        unique case (cmd_i.kind)
          rau_pkg::RES_ERR: begin
            res_num_q <= '0;
            res_den_q <= '0;
            status_q  <= rau_pkg::STAT_ZDIV;
          end
          rau_pkg::RES_ZERO: begin
            res_num_q <= '0;
            res_den_q <= 63'd1;
            status_q  <= rau_pkg::STAT_OK;
          end
          default: begin
            res_den_q <= quo_q[62:0];
            if (num_s_q ^ den_s_q) begin
              res_num_q <= signed'(neg_nq);
              status_q  <= rau_pkg::STAT_OK;
            end else if (nq_q[VW-1]) begin
              res_num_q <= 64'sh7FFF_FFFF_FFFF_FFFF;
              status_q  <= rau_pkg::STAT_OVF;
            end else begin
              res_num_q <= signed'(nq_q);
              status_q  <= rau_pkg::STAT_OK;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Status toward the controller
  assign stat_o.err      = (ad_q == '0) || (bd_q == '0) || (is_div && (bn_q == '0));
  assign stat_o.addsub   = (func_q == rau_pkg::FUNC_ADD) || is_sub;
  assign stat_o.zero     = (num_q == '0);
  assign stat_o.gcd_done = (u_q == '0) || (v_q == '0);
  assign stat_o.div_done = (cnt_q == rau_pkg::CNT_W'(VW));

  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign status_o  = status_q;

endmodule

[hw/rtl/rau_ctrl.sv]
// Controller of the rational arithmetic unit: sequences the datapath and
// owns both handshakes. Uses rau_pkg.
module rau_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rau_pkg::dp_cmd_t    cmd_o,
  input  rau_pkg::dp_stat_t   stat_i
);

  rau_pkg::ctrl_state_e state_q, state_d;
  rau_pkg::res_kind_e   kind_q, kind_d;
  logic                 out_valid_q, out_valid_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rau_pkg::S_IDLE;
      kind_q      <= rau_pkg::RES_NORM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = rau_pkg::OP_NONE;
    cmd_o.kind  = kind_q;
    unique case (state_q)
      rau_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = rau_pkg::OP_LOAD;
          state_d  = rau_pkg::S_MUL0;
        end
      end
      rau_pkg::S_MUL0: begin
        if (stat_i.err) begin
          kind_d  = rau_pkg::RES_ERR;
          state_d = rau_pkg::S_FIN;
        end else begin
          cmd_o.op = rau_pkg::OP_MUL0;
          state_d  = stat_i.addsub ? rau_pkg::S_MUL1 : rau_pkg::S_MUL2;
        end
      end
      rau_pkg::S_MUL1: begin
        cmd_o.op = rau_pkg::OP_MUL1;
        state_d  = rau_pkg::S_MUL2;
      end
      rau_pkg::S_MUL2: begin
        cmd_o.op = rau_pkg::OP_MUL2;
        state_d  = rau_pkg::S_SUM;
      end
      rau_pkg::S_SUM: begin
        cmd_o.op = rau_pkg::OP_SUM;
        state_d  = rau_pkg::S_CHECK;
      end
      rau_pkg::S_CHECK: begin
        if (stat_i.zero) begin
          kind_d  = rau_pkg::RES_ZERO;
          state_d = rau_pkg::S_FIN;
        end else begin
          kind_d   = rau_pkg::RES_NORM;
          cmd_o.op = rau_pkg::OP_GCD_INIT;
          state_d  = rau_pkg::S_GCD;
        end
      end
      rau_pkg::S_GCD: begin
        if (stat_i.gcd_done) begin
          cmd_o.op = rau_pkg::OP_DIVN_INIT;
          state_d  = rau_pkg::S_DIVN;
        end else begin
          cmd_o.op = rau_pkg::OP_GCD_STEP;
        end
      end
      rau_pkg::S_DIVN: begin
        if (stat_i.div_done) begin
          cmd_o.op = rau_pkg::OP_DIVD_INIT;
          state_d  = rau_pkg::S_DIVD;
        end else begin
          cmd_o.op = rau_pkg::OP_DIV_STEP;
        end
      end
      rau_pkg::S_DIVD: begin
        if (stat_i.div_done) begin
          state_d = rau_pkg::S_FIN;
        end else begin
          cmd_o.op = rau_pkg::OP_DIV_STEP;
        end
      end
      rau_pkg::S_FIN: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = rau_pkg::OP_FIN;
          out_valid_d = 1'b1;
          state_d     = rau_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rau_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != rau_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/rational_arith_unit_core.sv]
// Rational arithmetic unit: adds, subtracts, multiplies or divides two signed
// fractions and returns the result in lowest terms with a positive denominator.
// One transaction is worked at a time. It forms the products and sum on one
// shared 32x32 multiplier, runs the binary GCD loop (one subtract and shift
// per cycle), and forms the two quotients on one shared restoring divider
// (one bit per cycle). A zero denominator or zero divisor skips straight to
// the result; a zero result skips the GCD loop and the divider.
// A new transaction is taken while a finished result waits in the output
// register. Status 1 flags a zero denominator or divisor, status 2 a positive
// numerator that saturated.
module rational_arith_unit_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  logic signed [31:0]   a_num_i,
  input  logic signed [31:0]   a_den_i,
  input  logic signed [31:0]   b_num_i,
  input  logic signed [31:0]   b_den_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [63:0]   res_num_o,
  output logic [62:0]          res_den_o,
  output logic [1:0]           status_o
);

  localparam int OB = rau_pkg::OPERAND_BITS;

  rau_pkg::dp_cmd_t  cmd;
  rau_pkg::dp_stat_t stat;

  // Sequence control
  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Arithmetic
  rau_datapath u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .func_i    (func_i),
    .a_num_i   (a_num_i[OB-1:0]),
    .a_den_i   (a_den_i[OB-1:0]),
    .b_num_i   (b_num_i[OB-1:0]),
    .b_den_i   (b_den_i[OB-1:0]),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .status_o  (status_o)
  );

endmodule

[tb/testbench.sv]
// Self-checking testbench for rational_arith_unit_core: random and directed
// fraction operations checked against an in-bench reduction predictor.
// Depends on rau_pkg and the rational_arith_unit_core RTL.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    rau_pkg::func_e     func;
    logic signed [31:0] a_num, a_den, b_num, b_den;
  } frac_op_t;

  typedef struct {
    logic signed [63:0] num;
    logic [62:0]        den;
    rau_pkg::stat_e     status;
  } frac_res_t;

  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] func_i = '0;
  logic signed [31:0] a_num_i = '0, a_den_i = '0, b_num_i = '0, b_den_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [63:0] res_num_o;
  logic [62:0] res_den_o;
  logic [1:0] status_o;

  frac_op_t  pending_ops[$];
  frac_res_t reduced_q[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  feeding_done = 1'b0;
  bit  hold_sender = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  in_accepts = 0;
  int  in_pops = 0;

  rational_arith_unit_core dut (.*);

  // Run the clock: 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Draw a gap length: mostly zero or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] m, logic [63:0] n);
    logic [63:0] t;
    while (n != 0) begin
      t = m % n;
      m = n;
      n = t;
    end
    return m;
  endfunction

  // Predict the reduced fraction for one operation
  function automatic frac_res_t reduce_fraction(frac_op_t op);
    frac_res_t r;
    logic an_s, ad_s, bn_s, bd_s, n_s, d_s, q_s, p_s, res_neg;
    logic [63:0] an_m, ad_m, bn_m, bd_m, n_m, d_m, q_m, p_m, g, nm, dm;
    an_s = op.a_num[31]; an_m = an_s ? 64'(-65'(op.a_num)) : 64'(op.a_num);
    ad_s = op.a_den[31]; ad_m = ad_s ? 64'(-65'(op.a_den)) : 64'(op.a_den);
    bn_s = op.b_num[31]; bn_m = bn_s ? 64'(-65'(op.b_num)) : 64'(op.b_num);
    bd_s = op.b_den[31]; bd_m = bd_s ? 64'(-65'(op.b_den)) : 64'(op.b_den);
    r.status = rau_pkg::STAT_OK;
    if (ad_m == 0 || bd_m == 0 || (op.func == rau_pkg::FUNC_DIV && bn_m == 0)) begin
      r.num = 0; r.den = 0; r.status = rau_pkg::STAT_ZDIV;
      return r;
    end
    d_m = ad_m * bd_m; d_s = ad_s ^ bd_s;
    case (op.func)
      rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: begin
        q_m = bn_m * ad_m; q_s = bn_s ^ ad_s;
        if (op.func == rau_pkg::FUNC_SUB) q_s = ~q_s;
        if (q_m == 0) q_s = 1'b0;
        p_m = an_m * bd_m; p_s = (p_m != 0) && (an_s ^ bd_s);
        if (p_s == q_s) begin
          n_m = p_m + q_m; n_s = p_s;
        end else if (p_m >= q_m) begin
          n_m = p_m - q_m; n_s = p_s;
        end else begin
          n_m = q_m - p_m; n_s = q_s;
        end
      end
      rau_pkg::FUNC_MUL: begin
        n_m = an_m * bn_m; n_s = an_s ^ bn_s;
      end
      default: begin
        n_m = an_m * bd_m; n_s = an_s ^ bd_s;
        d_m = ad_m * bn_m; d_s = ad_s ^ bn_s;
      end
    endcase
    if (n_m == 0) begin
      r.num = 0; r.den = 1;
      return r;
    end
    res_neg = n_s ^ d_s;
    g = gcd64(n_m, d_m);
    nm = n_m / g;
    dm = d_m / g;
    if (res_neg) r.num = -nm;
    else if (nm[63]) begin
      r.num = 64'h7fff_ffff_ffff_ffff; r.status = rau_pkg::STAT_OVF;
    end else r.num = nm;
    r.den = dm[62:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // Random operand value: extremes, small, or full range
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(2)) - 1);
      3, 4: return 32'(int'($urandom_range(200)) - 100);
      5: return 32'(int'($urandom_range(40000)) - 20000) * 32'($urandom_range(3, 1));
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(rau_pkg::func_e f, logic [31:0] an, logic [31:0] ad,
                        logic [31:0] bn, logic [31:0] bd);
    frac_op_t op;
    op.func = f; op.a_num = an; op.a_den = ad; op.b_num = bn; op.b_den = bd;
    pending_ops.push_back(op);
  endtask

  // Fill the stimulus queue: directed cases, then random ones
  initial begin
    frac_op_t op;
    add_op(rau_pkg::FUNC_ADD, 1, 2, 1, 3);
    add_op(rau_pkg::FUNC_SUB, 1, 2, 1, 2);
    add_op(rau_pkg::FUNC_MUL, -3, 4, 2, -9);
    add_op(rau_pkg::FUNC_DIV, 5, 7, -10, 21);
    add_op(rau_pkg::FUNC_ADD, 1, 0, 1, 1);
    add_op(rau_pkg::FUNC_SUB, 1, 1, 1, 0);
    add_op(rau_pkg::FUNC_DIV, 3, 4, 0, 5);
    add_op(rau_pkg::FUNC_MUL, 0, -5, 7, 3);
    add_op(rau_pkg::FUNC_DIV, 0, 9, 7, -3);
    add_op(rau_pkg::FUNC_ADD, 32'h8000_0000, 1, 32'h8000_0000, 1);
    add_op(rau_pkg::FUNC_SUB, 32'h8000_0000, 1, 32'h8000_0000, 1);
    add_op(rau_pkg::FUNC_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
    add_op(rau_pkg::FUNC_MUL, 32'h8000_0000, 1, 32'h8000_0000, -1);
    add_op(rau_pkg::FUNC_DIV, 32'h8000_0000, 1, 1, 32'h8000_0000);
    add_op(rau_pkg::FUNC_ADD, 32'h8000_0000, -1, 32'h8000_0000, -1);
    add_op(rau_pkg::FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    add_op(rau_pkg::FUNC_SUB, 32'h7fff_ffff, 3, 32'h8000_0000, 7);
    add_op(rau_pkg::FUNC_MUL, 32'h7fff_ffff, 32'h7fff_ffff, -1, -1);
    add_op(rau_pkg::FUNC_DIV, -1, -1, -1, -1);
    add_op(rau_pkg::FUNC_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < 1130; i++) begin
      op.func = rau_pkg::func_e'($urandom_range(3));
      op.a_num = rand_operand(); op.a_den = rand_operand();
      op.b_num = rand_operand(); op.b_den = rand_operand();
      // Keep most operands well formed so reduction is exercised
      if ($urandom_range(9) != 0) begin
        if (op.a_den == 0) op.a_den = 1;
        if (op.b_den == 0) op.b_den = -1;
        if (op.func == rau_pkg::FUNC_DIV && op.b_num == 0) op.b_num = 3;
      end
      pending_ops.push_back(op);
    end
    feeding_done = 1'b1;
  end

  // Driver: present transactions at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && in_accepts == in_pops) begin
      // hold the stalled transaction
    end else begin
      if (in_accepts != in_pops) begin
        void'(pending_ops.pop_front());
        in_pops++;
        send_gap = pick_gap();
        if (pending_ops.size() == 600) hold_sender = 1'b1;
      end
      if (hold_sender && reduced_q.size() == 0) hold_sender = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (hold_sender || pending_ops.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        func_i  <= pending_ops[0].func;
        a_num_i <= pending_ops[0].a_num;
        a_den_i <= pending_ops[0].a_den;
        b_num_i <= pending_ops[0].b_num;
        b_den_i <= pending_ops[0].b_den;
      end
    end
    // advance the receiver stall pattern
    if (recv_gap > 0) begin
      recv_gap--;
      out_stall_i <= 1'b1;
    end else begin
      recv_gap = pick_gap();
      out_stall_i <= (recv_gap > 0) && ($urandom_range(1) == 1);
    end
  end

  // Monitor: predict on accepted input, check on accepted output
  always @(posedge clk_i) begin
    frac_op_t  op;
    frac_res_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        op.func = rau_pkg::func_e'(func_i);
        op.a_num = a_num_i; op.a_den = a_den_i;
        op.b_num = b_num_i; op.b_den = b_den_i;
        reduced_q.push_back(reduce_fraction(op));
        in_accepts++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (reduced_q.size() == 0) begin
          report("unexpected result", res_num_o, 64'(0));
        end else begin
          want = reduced_q.pop_front();
          if (res_num_o !== want.num) report("res_num", res_num_o, want.num);
          if (res_den_o !== want.den)
            report("res_den", 64'(res_den_o), 64'(want.den));
          if (status_o !== want.status)
            report("status", 64'(status_o), 64'(want.status));
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset, then wait for the drain and finish
  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    fork
      begin
        wait (feeding_done && pending_ops.size() == 0 && !in_valid_i
              && reduced_q.size() == 0);
        repeat (300) @(posedge clk_i);
        if (mismatches == 0 && reduced_q.size() == 0)
          $display("rational_arith_unit_core: match");
        else
          $display("rational_arith_unit_core: mismatch");
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("timeout waiting for a transaction");
        $display("rational_arith_unit_core: mismatch");
      end
    join_any
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/rau_pkg.sv
hw/rtl/rau_datapath.sv
hw/rtl/rau_ctrl.sv
hw/rtl/rational_arith_unit_core.sv
tb/testbench.sv
